@@ hw/rtl/arp_pkg.sv @@
// Shared constants, types and request/response structs of the arpeggiator.
`default_nettype none

package arp_pkg;

  localparam int PITCH_SLOTS = 6;
  localparam int SLOT_W      = 3;
  localparam int PITCH_W     = 15;
  localparam int STEP_W      = 5;
  localparam int OFFSET_W    = 4;

  localparam logic [OFFSET_W-1:0] MAX_OFFSET = 4'd10;
  localparam logic [SLOT_W-1:0]   LAST_SLOT  = 3'(PITCH_SLOTS - 1);

  localparam logic signed [PITCH_W-1:0] VOLT_HI = 15'sd10000;
  localparam logic signed [PITCH_W-1:0] VOLT_LO = -15'sd10000;

  // Remainder unit: one compare-subtract per cycle, top position first.
  localparam logic [2:0] REM_TOP_SHIFT = 3'(STEP_W - 1);

  typedef logic [1:0] pattern_t;
  localparam pattern_t PAT_RIGHT      = 2'd0;
  localparam pattern_t PAT_LEFT       = 2'd1;
  localparam pattern_t PAT_RIGHT_LEFT = 2'd2;
  localparam pattern_t PAT_LEFT_RIGHT = 2'd3;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] dividend;
    logic [SLOT_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic              done;
    logic [STEP_W-1:0] rem;
  } rem_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/arp_in_if.sv @@
// Input channel: one clock event word with pitches, mask and pattern.
`default_nettype none

interface arp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 clock_connected;
  logic [2:0]                           pattern;
  logic [arp_pkg::PITCH_SLOTS-1:0]      active_mask;
  logic signed [arp_pkg::PITCH_W-1:0]   pitch_0;
  logic signed [arp_pkg::PITCH_W-1:0]   pitch_1;
  logic signed [arp_pkg::PITCH_W-1:0]   pitch_2;
  logic signed [arp_pkg::PITCH_W-1:0]   pitch_3;
  logic signed [arp_pkg::PITCH_W-1:0]   pitch_4;
  logic signed [arp_pkg::PITCH_W-1:0]   pitch_5;

  modport source (output valid, clock_connected, pattern, active_mask,
                  pitch_0, pitch_1, pitch_2, pitch_3, pitch_4, pitch_5,
                  input ready);
  modport sink   (input valid, clock_connected, pattern, active_mask,
                  pitch_0, pitch_1, pitch_2, pitch_3, pitch_4, pitch_5,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/arp_out_if.sv @@
// Result channel: played note, its source input and end-of-cycle flag.
`default_nettype none

interface arp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [arp_pkg::PITCH_W-1:0]  note_voltage;
  logic [arp_pkg::SLOT_W-1:0]          source_number;
  logic                                end_of_cycle;

  modport source (output valid, note_voltage, source_number, end_of_cycle,
                  input ready);
  modport sink   (input valid, note_voltage, source_number, end_of_cycle,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/arp_rem.sv @@
// Iterative remainder unit: restoring compare-subtract, one bit a cycle.
`default_nettype none

module arp_rem (
  input  logic              clk,
  input  logic              rst_n,
  input  arp_pkg::rem_req_t req,
  output arp_pkg::rem_rsp_t rsp
);

  logic [arp_pkg::STEP_W-1:0] r_r, r_nxt;
  logic [arp_pkg::SLOT_W-1:0] d_r;
  logic [2:0]                 k_r, k_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [6:0]                 sub;
  logic                       fits;

  assign sub  = {4'b0, d_r} << k_r;
  assign fits = {2'b0, r_r} >= sub;

  always_comb begin
    r_nxt    = r_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      r_nxt    = req.dividend;
      k_nxt    = arp_pkg::REM_TOP_SHIFT;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        r_nxt = r_r - sub[arp_pkg::STEP_W-1:0];
      end
      if (k_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    if (req.start) begin
      d_r <= req.divisor;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = r_r;

endmodule

`default_nettype wire

@@ hw/rtl/clocked_arpeggiator.sv @@
// Top level of the clocked arpeggiator: sequencer, held pitches, result register.
//
//   channel  | dir | handshake         | word
//   ---------+-----+-------------------+---------------------------------------------
//   in_if    | in  | valid/ready       | clock_connected, pattern, active_mask, pitch_0..5
//   out_if   | out | valid/ready       | note_voltage, source_number, end_of_cycle
//   cfg_*    | in  | cfg_wr_en         | cfg_wr_data = offset_steps
//
// A playing edge runs through capture, 5 steps of the shared remainder unit, slot latch
// and result load. A cycle start runs through capture, a scan of the pitch inputs and
// the remainder unit. A note that ends the pattern restarts at once.
// in_if.ready is high only while the sequencer is idle. The result load waits while
// the output register still holds an untaken word. rst_n is synchronous and clears
// the sequencer, the cycle state, the offset register and the output valid.
`default_nettype none

module clocked_arpeggiator (
  input  logic                             clk,
  input  logic                             rst_n,
  arp_in_if.sink                           in_if,
  arp_out_if.source                        out_if,
  input  logic                             cfg_wr_en,
  input  logic [arp_pkg::OFFSET_W-1:0]     cfg_wr_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PMOD = 5'b00010,
    ST_POUT = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_SMOD = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  logic                           running_r, running_nxt;
  arp_pkg::pattern_t              pat_r, pat_nxt;
  logic [arp_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [arp_pkg::STEP_W-1:0]     end_r, end_nxt;
  logic [arp_pkg::SLOT_W-1:0]     pitch_count_r, pitch_count_nxt;
  logic [arp_pkg::SLOT_W-1:0]     scan_r, scan_nxt;
  logic [arp_pkg::SLOT_W-1:0]     n_r, n_nxt;
  logic [arp_pkg::SLOT_W-1:0]     slot_r;
  logic [arp_pkg::OFFSET_W-1:0]   cfg_offset_r;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [arp_pkg::PITCH_W-1:0] out_note_r;
  logic [arp_pkg::SLOT_W-1:0]     out_src_r;
  logic                           out_eoc_r;

  // captured input word
  logic signed [arp_pkg::PITCH_W-1:0] in_pitch_r [arp_pkg::PITCH_SLOTS];
  logic [arp_pkg::PITCH_SLOTS-1:0]    in_mask_r;
  logic [2:0]                         in_pattern_r;

  // held pitches of the running cycle
  logic signed [arp_pkg::PITCH_W-1:0] held_pitch_r [arp_pkg::PITCH_SLOTS];
  logic [arp_pkg::SLOT_W-1:0]         held_src_r   [arp_pkg::PITCH_SLOTS];

  arp_pkg::rem_req_t rem_req;
  arp_pkg::rem_rsp_t rem_rsp;

  logic                           in_acc;
  logic                           out_free;
  logic [arp_pkg::SLOT_W-1:0]     mag;
  logic signed [6:0]              diff7, absd7, t7, abst7;
  logic [arp_pkg::STEP_W-1:0]     play_div;
  logic                           done_flag;
  logic signed [arp_pkg::PITCH_W-1:0] sel_pitch, clamp_pitch;
  logic                           cur_bit;
  logic [arp_pkg::SLOT_W-1:0]     n_inc, n_final;
  logic                           scan_last;
  logic [arp_pkg::OFFSET_W-1:0]   off_sat;
  logic [arp_pkg::SLOT_W-1:0]     q3;
  logic [arp_pkg::SLOT_W-1:0]     m_start;
  logic [arp_pkg::STEP_W-1:0]     e5, off5;

  arp_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  // play position before the modulo: |m-c| or |m-|m-c||
  assign mag   = pitch_count_r - 3'd1;
  assign diff7 = $signed({4'b0, mag}) - $signed({2'b0, step_r});
  assign absd7 = diff7[6] ? -diff7 : diff7;
  assign t7    = $signed({4'b0, mag}) - absd7;
  assign abst7 = t7[6] ? -t7 : t7;

  always_comb begin
    case (pat_r)
      arp_pkg::PAT_RIGHT_LEFT: play_div = abst7[arp_pkg::STEP_W-1:0];
      arp_pkg::PAT_LEFT_RIGHT: play_div = absd7[arp_pkg::STEP_W-1:0];
      default:                 play_div = step_r;
    endcase
  end

  always_comb begin
    case (pat_r)
      arp_pkg::PAT_RIGHT: done_flag = ({1'b0, step_r} + 6'd1) >= {3'b0, pitch_count_r};
      arp_pkg::PAT_LEFT:  done_flag = (step_r == '0);
      default:            done_flag = (step_r == end_r);
    endcase
  end

  assign sel_pitch = held_pitch_r[slot_r];
  always_comb begin
    if (sel_pitch > arp_pkg::VOLT_HI) begin
      clamp_pitch = arp_pkg::VOLT_HI;
    end else if (sel_pitch < arp_pkg::VOLT_LO) begin
      clamp_pitch = arp_pkg::VOLT_LO;
    end else begin
      clamp_pitch = sel_pitch;
    end
  end

  // compaction scan, one pitch input a cycle
  assign cur_bit   = in_mask_r[scan_r];
  assign n_inc     = n_r + {2'b0, cur_bit};
  assign scan_last = (scan_r == arp_pkg::LAST_SLOT);
  assign n_final   = (n_inc == '0) ? 3'd1 : n_inc;

  assign off_sat = (cfg_offset_r > arp_pkg::MAX_OFFSET) ? arp_pkg::MAX_OFFSET : cfg_offset_r;
  assign off5    = {1'b0, off_sat};
  assign q3      = rem_rsp.rem[arp_pkg::SLOT_W-1:0];
  assign m_start = pitch_count_r - 3'd1;
  assign e5      = (m_start == '0) ? 5'd1 : ({1'b0, m_start, 1'b0} - 5'd1);

  always_comb begin
    rem_req.start    = 1'b0;
    rem_req.dividend = play_div;
    rem_req.divisor  = pitch_count_r;
    if (state_r == ST_SCAN) begin
      rem_req.dividend = off5;
      rem_req.divisor  = n_final;
      rem_req.start    = scan_last;
    end else if (state_r == ST_IDLE) begin
      rem_req.start    = in_acc && in_if.clock_connected && running_r;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    running_nxt     = running_r;
    pat_nxt         = pat_r;
    step_nxt        = step_r;
    end_nxt         = end_r;
    pitch_count_nxt = pitch_count_r;
    scan_nxt        = scan_r;
    n_nxt           = n_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_if.clock_connected) begin
            running_nxt = 1'b0;
          end else if (running_r) begin
            state_nxt = ST_PMOD;
          end else begin
            scan_nxt  = '0;
            n_nxt     = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_PMOD: begin
        if (rem_rsp.done) begin
          state_nxt = ST_POUT;
        end
      end
      ST_POUT: begin
        // hold until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          step_nxt      = (pat_r == arp_pkg::PAT_LEFT) ? step_r - 5'd1 : step_r + 5'd1;
          if (done_flag) begin
            scan_nxt  = '0;
            n_nxt     = '0;
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        n_nxt    = n_inc;
        scan_nxt = scan_r + 3'd1;
        if (scan_last) begin
          pitch_count_nxt = n_final;
          pat_nxt         = in_pattern_r[2] ? arp_pkg::PAT_RIGHT : in_pattern_r[1:0];
          state_nxt       = ST_SMOD;
        end
      end
      ST_SMOD: begin
        if (rem_rsp.done) begin
          running_nxt = 1'b1;
          state_nxt   = ST_IDLE;
          case (pat_r)
            arp_pkg::PAT_RIGHT: begin
              step_nxt = rem_rsp.rem;
              end_nxt  = {2'b0, m_start};
            end
            arp_pkg::PAT_LEFT: begin
              step_nxt = {2'b0, m_start - q3};
              end_nxt  = '0;
            end
            default: begin
              step_nxt = off5;
              if (e5 < off5) begin
                end_nxt = off5;
              end else if (off5 != '0) begin
                end_nxt = e5 + 5'd1;
              end else begin
                end_nxt = e5;
              end
            end
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      running_r     <= 1'b0;
      pat_r         <= arp_pkg::PAT_RIGHT;
      step_r        <= '0;
      end_r         <= '0;
      pitch_count_r <= '0;
      scan_r        <= '0;
      n_r           <= '0;
      out_valid_r   <= 1'b0;
      cfg_offset_r  <= '0;
    end else begin
      state_r       <= state_nxt;
      running_r     <= running_nxt;
      pat_r         <= pat_nxt;
      step_r        <= step_nxt;
      end_r         <= end_nxt;
      pitch_count_r <= pitch_count_nxt;
      scan_r        <= scan_nxt;
      n_r           <= n_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_offset_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_pitch_r[0] <= in_if.pitch_0;
      in_pitch_r[1] <= in_if.pitch_1;
      in_pitch_r[2] <= in_if.pitch_2;
      in_pitch_r[3] <= in_if.pitch_3;
      in_pitch_r[4] <= in_if.pitch_4;
      in_pitch_r[5] <= in_if.pitch_5;
      in_mask_r     <= in_if.active_mask;
      in_pattern_r  <= in_if.pattern;
    end
    if ((state_r == ST_PMOD) && rem_rsp.done) begin
      slot_r <= q3;
    end
    if ((state_r == ST_POUT) && out_free) begin
      out_note_r <= clamp_pitch;
      out_src_r  <= held_src_r[slot_r];
      out_eoc_r  <= done_flag;
    end
    if (state_r == ST_SCAN) begin
      if (cur_bit) begin
        held_pitch_r[n_r] <= in_pitch_r[scan_r];
        held_src_r[n_r]   <= scan_r;
      end
      // no active input: hold a single 0 mV pitch from input 0
      if (scan_last && (n_inc == '0)) begin
        held_pitch_r[0] <= '0;
        held_src_r[0]   <= '0;
      end
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.note_voltage  = out_note_r;
  assign out_if.source_number = out_src_r;
  assign out_if.end_of_cycle  = out_eoc_r;

endmodule

`default_nettype wire

@@ hw/rtl/arp_checker.sv @@
// Port-level assertions for the arpeggiator, attached by bind.
`default_nettype none

module arp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_clock_connected,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [arp_pkg::PITCH_W-1:0] out_note_voltage,
  input logic [arp_pkg::SLOT_W-1:0]         out_source_number,
  input logic                               out_end_of_cycle
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_note_voltage)
      && $stable(out_source_number) && $stable(out_end_of_cycle))
    else $error("result word changed while stalled");

  a_busy_after_edge: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_clock_connected |=> !in_ready)
    else $error("block still ready after taking a clock edge");

  a_unplug_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_clock_connected && !out_valid |=> !out_valid)
    else $error("result appeared after an unplug word");

  a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_note_voltage <= arp_pkg::VOLT_HI
      && out_note_voltage >= arp_pkg::VOLT_LO)
    else $error("note voltage outside the clamp range");

  a_source_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_source_number <= arp_pkg::LAST_SLOT)
    else $error("source number beyond the last pitch input");

endmodule

bind clocked_arpeggiator arp_checker u_arp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .in_clock_connected (in_if.clock_connected),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_note_voltage   (out_if.note_voltage),
  .out_source_number  (out_if.source_number),
  .out_end_of_cycle   (out_if.end_of_cycle)
);

`default_nettype wire
